### hw/rtl/ibf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ibf_pkg
// Shared constants, entry layout and index helpers for the source address
// blacklist filter.
// ----------------------------------------------------------------------------
package ibf_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int EXT_W = IDX_W + 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic [1:0] MODE_PACKET = 2'd0;
  localparam logic [1:0] MODE_ADD    = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;
  localparam logic [1:0] MODE_QUERY  = 2'd3;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [1:0] STATUS_PRESENT   = 2'd3;

  localparam logic [15:0] ETH_HDR_BYTES  = 16'd14;
  localparam logic [15:0] IPV4_MIN_BYTES = 16'd34;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [63:0] hits;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // xor fold of the address, then one conditional subtract into range
  function automatic logic [IDX_W-1:0] home_idx(input logic [31:0] addr);
    logic [IDX_W-1:0] h;
    h = '0;
    for (int i = 0; i < 32; i++) begin
      h[i % IDX_W] = h[i % IDX_W] ^ addr[i];
    end
    if ({1'b0, h} >= EXT_W'(TABLE_ENTRIES)) begin
      h = h - IDX_W'(TABLE_ENTRIES);
    end
    return h;
  endfunction

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] n;
    n = (i == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : i + IDX_W'(1);
    return n;
  endfunction

  // forward distance around the ring from a_idx to b_idx
  function automatic logic [IDX_W-1:0] ring_dist(input logic [IDX_W-1:0] a_idx,
                                                 input logic [IDX_W-1:0] b_idx);
    logic [EXT_W-1:0] d;
    d = {1'b0, b_idx} - {1'b0, a_idx};
    if (b_idx < a_idx) begin
      d = d + EXT_W'(TABLE_ENTRIES);
    end
    return d[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

### hw/rtl/ibf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ibf_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module ibf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### hw/rtl/ipv4_source_blacklist_filter.sv
// flow: S_RESULT loads the output registers; a frame needing no lookup goes
//   there straight, a lookup passes S_PROBE for each probe, and a remove adds
//   an S_SHIFT step per entry inspected while closing the gap, plus S_HOLE
//   if the scan spans the table; each probe or shift step is one read of the
//   single-read-port table ram, and only S_IDLE takes a new item (in_stall)
// reset: a pass clears every table slot, in_stall is high meanwhile
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_source_blacklist_filter
// Open-addressed hash table of blocked IPv4 source addresses with linear
// probing, per-entry hit counters and a global drop counter.
// ----------------------------------------------------------------------------
module ipv4_source_blacklist_filter
  import ibf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic [15:0] in_frame_len,
  input  wire logic [15:0] in_ether_type,
  input  wire logic [31:0] in_ip_addr,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_verdict,
  output logic [1:0]       out_status,
  output logic [63:0]      out_entry_hits,
  output logic [63:0]      out_drop_count
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_PROBE  = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_HOLE   = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] clr_idx_r, clr_idx_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic [63:0]      drop_r, drop_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [1:0]       mode_r, mode_nxt;
  logic [31:0]      addr_r, addr_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] probes_r, probes_nxt;
  logic [IDX_W-1:0] hole_r, hole_nxt;
  logic             res_verdict_r, res_verdict_nxt;
  logic [1:0]       res_status_r, res_status_nxt;
  logic [63:0]      res_hits_r, res_hits_nxt;
  logic             out_verdict_r, out_verdict_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [63:0]      out_hits_r, out_hits_nxt;
  logic [63:0]      out_drop_r, out_drop_nxt;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;

  entry_t           rd_entry;
  entry_t           wr_entry;
  logic             probe_hit;
  logic             probe_miss;
  logic             need_lookup;
  logic [IDX_W-1:0] in_home;
  logic [IDX_W-1:0] rd_home;
  logic             can_move;

  ibf_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign rd_entry   = entry_t'(mem_rdata);
  assign probe_hit  = rd_entry.valid && (rd_entry.key == addr_r);
  assign probe_miss = !rd_entry.valid || (probes_r == CNT_W'(TABLE_ENTRIES));
  assign in_home    = home_idx(in_ip_addr);
  assign rd_home    = home_idx(rd_entry.key);
  // an entry may fill the hole unless its home lies between hole and itself
  assign can_move   = ring_dist(rd_home, idx_r) >= ring_dist(hole_r, idx_r);
  assign need_lookup = (in_mode != MODE_PACKET) ||
                       ((in_frame_len >= ETH_HDR_BYTES) &&
                        (in_ether_type == ETHERTYPE_IPV4) &&
                        (in_frame_len >= IPV4_MIN_BYTES));

  always_comb begin
    state_nxt       = state_r;
    clr_idx_nxt     = clr_idx_r;
    occ_nxt         = occ_r;
    drop_nxt        = drop_r;
    out_valid_nxt   = out_valid_r;
    mode_nxt        = mode_r;
    addr_nxt        = addr_r;
    idx_nxt         = idx_r;
    probes_nxt      = probes_r;
    hole_nxt        = hole_r;
    res_verdict_nxt = res_verdict_r;
    res_status_nxt  = res_status_r;
    res_hits_nxt    = res_hits_r;
    out_verdict_nxt = out_verdict_r;
    out_status_nxt  = out_status_r;
    out_hits_nxt    = out_hits_r;
    out_drop_nxt    = out_drop_r;
    mem_we          = 1'b0;
    mem_waddr       = idx_r;
    wr_entry        = '0;
    mem_re          = 1'b0;
    mem_raddr       = next_idx(idx_r);

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_idx_r;
        clr_idx_nxt = next_idx(clr_idx_r);
        if (clr_idx_r == IDX_W'(TABLE_ENTRIES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt        = in_mode;
          addr_nxt        = in_ip_addr;
          res_verdict_nxt = 1'b0;
          res_status_nxt  = STATUS_OK;
          res_hits_nxt    = '0;
          if (need_lookup) begin
            mem_re     = 1'b1;
            mem_raddr  = in_home;
            idx_nxt    = in_home;
            probes_nxt = CNT_W'(1);
            state_nxt  = S_PROBE;
          end else begin
            state_nxt = S_RESULT;
          end
        end
      end
      S_PROBE: begin
        if (probe_hit) begin
          case (mode_r)
            MODE_PACKET: begin
              wr_entry        = rd_entry;
              wr_entry.hits   = rd_entry.hits + 64'd1;
              mem_we          = 1'b1;
              res_verdict_nxt = 1'b1;
              res_hits_nxt    = rd_entry.hits + 64'd1;
              drop_nxt        = drop_r + 64'd1;
              state_nxt       = S_RESULT;
            end
            MODE_ADD: begin
              res_status_nxt = STATUS_PRESENT;
              state_nxt      = S_RESULT;
            end
            MODE_REMOVE: begin
              // backward-shift delete starting at the freed slot
              occ_nxt    = occ_r - CNT_W'(1);
              hole_nxt   = idx_r;
              idx_nxt    = next_idx(idx_r);
              mem_re     = 1'b1;
              probes_nxt = CNT_W'(1);
              state_nxt  = S_SHIFT;
            end
            MODE_QUERY: begin
              res_hits_nxt = rd_entry.hits;
              state_nxt    = S_RESULT;
            end
            default: begin
              state_nxt = S_RESULT;
            end
          endcase
        end else if (probe_miss) begin
          case (mode_r)
            MODE_ADD: begin
              if (occ_r == CNT_W'(TABLE_ENTRIES)) begin
                res_status_nxt = STATUS_FULL;
              end else begin
                wr_entry.valid = 1'b1;
                wr_entry.key   = addr_r;
                wr_entry.hits  = '0;
                mem_we         = 1'b1;
                occ_nxt        = occ_r + CNT_W'(1);
              end
            end
            MODE_REMOVE, MODE_QUERY: begin
              res_status_nxt = STATUS_NOT_FOUND;
            end
            default: begin
              res_status_nxt = STATUS_OK;
            end
          endcase
          state_nxt = S_RESULT;
        end else begin
          idx_nxt    = next_idx(idx_r);
          mem_re     = 1'b1;
          probes_nxt = probes_r + CNT_W'(1);
        end
      end
      S_SHIFT: begin
        mem_waddr = hole_r;
        if (!rd_entry.valid) begin
          mem_we    = 1'b1;
          state_nxt = S_RESULT;
        end else begin
          if (can_move) begin
            wr_entry = rd_entry;
            mem_we   = 1'b1;
            hole_nxt = idx_r;
          end
          if (probes_r == CNT_W'(TABLE_ENTRIES - 1)) begin
            state_nxt = S_HOLE;
          end else begin
            idx_nxt    = next_idx(idx_r);
            mem_re     = 1'b1;
            probes_nxt = probes_r + CNT_W'(1);
          end
        end
      end
      S_HOLE: begin
        mem_we    = 1'b1;
        mem_waddr = hole_r;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_verdict_nxt = res_verdict_r;
          out_status_nxt  = res_status_r;
          out_hits_nxt    = res_hits_r;
          out_drop_nxt    = drop_r;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    mem_wdata = ENTRY_W'(wr_entry);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      occ_r       <= '0;
      drop_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      occ_r       <= occ_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r        <= mode_nxt;
    addr_r        <= addr_nxt;
    idx_r         <= idx_nxt;
    probes_r      <= probes_nxt;
    hole_r        <= hole_nxt;
    res_verdict_r <= res_verdict_nxt;
    res_status_r  <= res_status_nxt;
    res_hits_r    <= res_hits_nxt;
    out_verdict_r <= out_verdict_nxt;
    out_status_r  <= out_status_nxt;
    out_hits_r    <= out_hits_nxt;
    out_drop_r    <= out_drop_nxt;
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_verdict    = out_verdict_r;
  assign out_status     = out_status_r;
  assign out_entry_hits = out_hits_r;
  assign out_drop_count = out_drop_r;

endmodule
`default_nettype wire

### hw/rtl/ibf_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ibf_checker
// Port-level checks for the source address blacklist filter.
// ----------------------------------------------------------------------------
module ibf_checker
  import ibf_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  in_mode,
  input wire logic [15:0] in_frame_len,
  input wire logic [15:0] in_ether_type,
  input wire logic [31:0] in_ip_addr,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_verdict,
  input wire logic [1:0]  out_status,
  input wire logic [63:0] out_entry_hits,
  input wire logic [63:0] out_drop_count
);

  // a stalled input beat stays up with its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_mode) && $stable(in_frame_len) &&
                             $stable(in_ether_type) && $stable(in_ip_addr))
    else $error("input beat changed while stalled");

  // a stalled result beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_verdict) && $stable(out_status) &&
                               $stable(out_entry_hits) && $stable(out_drop_count))
    else $error("result payload changed while stalled");

  // a drop is only ever reported with ok status
  a_drop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_verdict |-> out_status == STATUS_OK)
    else $error("drop verdict with non-ok status");

  // failed management operations carry no counter
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STATUS_OK |-> out_entry_hits == 64'd0 && !out_verdict)
    else $error("failed operation reports a counter");

endmodule

bind ipv4_source_blacklist_filter ibf_checker u_ibf_checker (.*);
`default_nettype wire
